FILE: rtl/cmsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmsr_pkg
// Shared types and constants for the CPU mailbox and shared RAM interface.
// ----------------------------------------------------------------------------
package cmsr_pkg;

  // Access codes
  typedef enum logic [3:0] {
    OP_HOST_DATA_RD = 4'd0,
    OP_HOST_DATA_WR = 4'd1,
    OP_HOST_STATUS  = 4'd2,
    OP_RESET_FLAGS  = 4'd3,
    OP_SND_DATA_RD  = 4'd4,
    OP_SND_DATA_WR  = 4'd5,
    OP_SND_STATUS   = 4'd6,
    OP_LATCH_WR     = 4'd7,
    OP_IRQ_CLR      = 4'd8,
    OP_COM_RD       = 4'd9,
    OP_COM_WR       = 4'd10,
    OP_DAC_WR       = 4'd11,
    OP_GEN_IRQ      = 4'd12,
    OP_ADDR_WR      = 4'd13,
    OP_ROM_RD       = 4'd14,
    OP_DSP_COM_RD   = 4'd15
  } opcode_e;

  localparam int unsigned PtrW      = 20;
  localparam int unsigned RomLenW   = 21;
  localparam int unsigned LatchRamEnBit = 3;

  localparam logic [12:0] HostStatusLow = 13'h1fff;
  localparam logic [13:0] SndStatusLow  = 14'h2000;
  localparam logic [11:0] DacMsbFlip    = 12'h800;
  localparam logic [15:0] GatedReadVal  = 16'hffff;
  localparam logic [RomLenW-1:0] RomLenReset = 21'h100000;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [8:0]  offset;
    logic [15:0] data;
    logic [15:0] byte_mask;
    logic [7:0]  rom_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0]     read_data;
    logic            host_irq_line;
    logic            dsp_irq_line;
    logic [11:0]     dac_value;
    logic            dac_strobe;
    logic [7:0]      latch_bits;
    logic [PtrW-1:0] rom_address;
  } out_item_t;

  function automatic logic [15:0] merge_masked(logic [15:0] old_w, logic [15:0] new_w,
                                               logic [15:0] mask);
    return (old_w & ~mask) | (new_w & mask);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cpu_mailbox_and_shared_ram_interface.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_mailbox_and_shared_ram_interface
// Host/sound/DSP mailboxes, interrupts, addressable latch, shared RAM and
// ROM pointer. One bus access per item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the RAM read stage, then the output register.
// Throughput: one item per cycle while the output drains and no clearing pass
//   runs; the shared RAM has one read and one write port, and a masked RAM
//   write completes in the stage after its read.
// Reset: all control registers take their reset values at once; the shared RAM
//   is then zeroed by a clearing pass over all SHARED_WORDS words, during which no item is taken.
module cpu_mailbox_and_shared_ram_interface
  import cmsr_pkg::*;
#(
  // Shared RAM depth in words; must be a power of two (16..4096).
  parameter int unsigned SHARED_WORDS = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire in_item_t           in_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      out_item_t          out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [RomLenW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(SHARED_WORDS);

  // --------------------------------------------------------------------------
  // Architectural state. All of it except the RAM and the ROM length updates on the accept edge.
  // --------------------------------------------------------------------------
  logic [RomLenW-1:0] rom_len_q;
  logic [15:0]        h2s_word_q, h2s_word_d;
  logic [15:0]        s2h_word_q, s2h_word_d;
  logic               host_full_q, host_full_d;
  logic               snd_full_q, snd_full_d;
  logic               dsp_irq_q, dsp_irq_d;
  logic [7:0]         latch_q, latch_d;
  logic [PtrW-1:0]    ptr_q, ptr_d;

  // Shared RAM, clearing pass after reset
  logic [15:0]     ram_q [SHARED_WORDS];
  logic [15:0]     ram_rdata_q;
  logic            clr_busy_q;
  logic [IdxW-1:0] clr_idx_q;

  // Stage 1: item whose RAM read is in flight
  logic            s1_valid_q;
  logic            s1_ram_rd_q;   // read_data comes from RAM
  logic            s1_ram_wr_q;   // masked RAM write
  logic [IdxW-1:0] s1_idx_q;
  logic [15:0]     s1_data_q;
  logic [15:0]     s1_mask_q;
  out_item_t       s1_res_q, s1_res_d;
  logic            s1_ram_rd_d, s1_ram_wr_d;
  logic [IdxW-1:0] rd_idx;

  // Last RAM write, forwarded to the next item whose read hit the same edge
  logic            lw_valid_q;
  logic [IdxW-1:0] lw_idx_q;
  logic [15:0]     lw_data_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic      accept;
  logic      s1_adv;
  logic      ram_en;
  logic [15:0] ram_word;
  logic [15:0] ram_wdata;
  logic        ram_we;
  opcode_e     op;

  assign op     = opcode_e'(in_item_i.opcode);
  assign ram_en = latch_q[LatchRamEnBit];

  // Stage 1 moves on when the output register is free or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Access decode and next state
  // --------------------------------------------------------------------------
  always_comb begin
    h2s_word_d  = h2s_word_q;
    s2h_word_d  = s2h_word_q;
    host_full_d = host_full_q;
    snd_full_d  = snd_full_q;
    dsp_irq_d   = dsp_irq_q;
    latch_d     = latch_q;
    ptr_d       = ptr_q;
    s1_ram_rd_d = 1'b0;
    s1_ram_wr_d = 1'b0;
    rd_idx      = IdxW'(in_item_i.offset);
    s1_res_d    = '0;

    unique case (op)
      OP_HOST_DATA_RD: begin
        snd_full_d         = 1'b0;
        s1_res_d.read_data = s2h_word_q;
      end
      OP_HOST_DATA_WR: begin
        h2s_word_d  = in_item_i.data;
        host_full_d = 1'b1;
      end
      OP_HOST_STATUS: s1_res_d.read_data = {host_full_q, snd_full_q, 1'b0, HostStatusLow};
      OP_RESET_FLAGS: begin
        host_full_d = 1'b0;
        snd_full_d  = 1'b0;
      end
      OP_SND_DATA_RD: begin
        host_full_d        = 1'b0;
        s1_res_d.read_data = h2s_word_q;
      end
      OP_SND_DATA_WR: begin
        s2h_word_d = merge_masked(s2h_word_q, in_item_i.data, in_item_i.byte_mask);
        snd_full_d = 1'b1;
      end
      OP_SND_STATUS: s1_res_d.read_data = {host_full_q, snd_full_q, SndStatusLow};
      OP_LATCH_WR:   latch_d[in_item_i.offset[2:0]] = in_item_i.offset[3];
      OP_IRQ_CLR:    dsp_irq_d = 1'b0;
      OP_COM_RD: begin
        if (ram_en) begin
          s1_ram_rd_d = 1'b1;
        end else begin
          s1_res_d.read_data = GatedReadVal;
        end
      end
      OP_COM_WR: s1_ram_wr_d = ram_en;
      OP_DAC_WR: begin
        s1_res_d.dac_value  = in_item_i.data[15:4] ^ DacMsbFlip;
        s1_res_d.dac_strobe = 1'b1;
      end
      OP_GEN_IRQ: dsp_irq_d = 1'b1;
      OP_ADDR_WR: begin
        if (in_item_i.offset == '0) begin
          ptr_d[PtrW-1:16] = in_item_i.data[3:0];
        end else begin
          ptr_d[15:0] = in_item_i.data;
        end
      end
      OP_ROM_RD: begin
        if ({1'b0, ptr_q} < rom_len_q) begin
          s1_res_d.read_data = {1'b0, in_item_i.rom_byte, 7'b0};
        end
        ptr_d = ptr_q + PtrW'(1);
      end
      OP_DSP_COM_RD: begin
        s1_ram_rd_d = 1'b1;
        rd_idx      = ptr_q[IdxW-1:0];
        ptr_d       = ptr_q + PtrW'(1);
      end
      default: ;
    endcase

    s1_res_d.host_irq_line = host_full_d;
    s1_res_d.dsp_irq_line  = dsp_irq_d;
    s1_res_d.latch_bits    = latch_d;
    // Pointer reads report the address they used; everything else the new one.
    s1_res_d.rom_address   = (op == OP_ROM_RD || op == OP_DSP_COM_RD) ? ptr_q : ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_len_q   <= RomLenReset;
      h2s_word_q  <= '0;
      s2h_word_q  <= '0;
      host_full_q <= 1'b0;
      snd_full_q  <= 1'b0;
      dsp_irq_q   <= 1'b0;
      latch_q     <= '0;
      ptr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        rom_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        h2s_word_q  <= h2s_word_d;
        s2h_word_q  <= s2h_word_d;
        host_full_q <= host_full_d;
        snd_full_q  <= snd_full_d;
        dsp_irq_q   <= dsp_irq_d;
        latch_q     <= latch_d;
        ptr_q       <= ptr_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ram_rd_q <= s1_ram_rd_d;
      s1_ram_wr_q <= s1_ram_wr_d;
      s1_idx_q    <= rd_idx;
      s1_data_q   <= in_item_i.data;
      s1_mask_q   <= in_item_i.byte_mask;
      s1_res_q    <= s1_res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Shared RAM: read issued on accept, masked write retired in stage 1.
  // A write on the same edge as the following read is forwarded.
  // --------------------------------------------------------------------------
  assign ram_word  = (lw_valid_q && lw_idx_q == s1_idx_q) ? lw_data_q : ram_rdata_q;
  assign ram_wdata = merge_masked(ram_word, s1_data_q, s1_mask_q);
  assign ram_we    = s1_adv && s1_ram_wr_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      ram_q[clr_idx_q] <= '0;
    end else if (ram_we) begin
      ram_q[s1_idx_q] <= ram_wdata;
    end
    if (accept) begin
      ram_rdata_q <= ram_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      lw_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
        if (clr_idx_q == IdxW'(SHARED_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (ram_we) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      lw_idx_q  <= s1_idx_q;
      lw_data_q <= ram_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // RAM reads take their data from the read stage.
  always_comb begin
    out_d = s1_res_q;
    if (s1_ram_rd_q) begin
      out_d.read_data = ram_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/cmsr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmsr_checker
// Port-level checks for the CPU mailbox and shared RAM interface.
// ----------------------------------------------------------------------------
module cmsr_checker
  import cmsr_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // Result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // DAC code only on a DAC write
  a_dac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.dac_strobe |-> out_item_o.dac_value == '0)
    else $error("DAC code without strobe");

  // A DAC write returns no read data
  a_dac_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.dac_strobe |-> out_item_o.read_data == '0)
    else $error("read data on DAC write");

endmodule

bind cpu_mailbox_and_shared_ram_interface cmsr_checker u_cmsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire

FILE: tb/cpu_mailbox_and_shared_ram_interface_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_mailbox_and_shared_ram_interface_test
// Self-checking bench for the host/sound/DSP mailbox and shared RAM glue.
// A directed run covers the status words, flag handling, latch gating, ROM
// pointer wrap and the ROM length cutoff. Random traffic then follows under
// several ROM lengths. It mixes single accesses, pointer-load-and-read runs
// and mailbox exchanges, with random stalls on both sides, one quiet stretch
// and one long output hold-off. An in-bench model of the block predicts every
// result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module cpu_mailbox_and_shared_ram_interface_test;
  import cmsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHARED_WORDS = 512;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  // --------------------------------------------------------------------------
  // Result predictor and checker
  // --------------------------------------------------------------------------
  class mailbox_scoreboard;
    logic [15:0]        h2s_word;
    logic [15:0]        s2h_word;
    logic               host_full;
    logic               snd_full;
    logic               irq3_pending;
    logic [7:0]         latch;
    logic [PtrW-1:0]    snd_ptr;
    logic [15:0]        ram [SHARED_WORDS];
    logic [RomLenW-1:0] rom_len;
    out_item_t          pending_results[$];
    int                 errors;

    function new();
      h2s_word     = '0;
      s2h_word     = '0;
      host_full    = 1'b0;
      snd_full     = 1'b0;
      irq3_pending = 1'b0;
      latch        = '0;
      snd_ptr      = '0;
      rom_len      = RomLenReset;
      errors       = 0;
      foreach (ram[i]) ram[i] = '0;
    endfunction

    function void set_rom_length(logic [RomLenW-1:0] v);
      rom_len = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted access to the model and queue the result it implies.
    function void note_access(in_item_t it);
      out_item_t   r;
      int unsigned idx;
      logic        ram_on;
      logic        ptr_op;
      r      = '0;
      ram_on = latch[LatchRamEnBit];
      idx    = it.offset % SHARED_WORDS;
      ptr_op = 1'b0;
      r.rom_address = snd_ptr;
      case (opcode_e'(it.opcode))
        OP_HOST_DATA_RD: begin
          snd_full    = 1'b0;
          r.read_data = s2h_word;
        end
        OP_HOST_DATA_WR: begin
          h2s_word  = it.data;
          host_full = 1'b1;
        end
        OP_HOST_STATUS:  r.read_data = {host_full, snd_full, 1'b0, HostStatusLow};
        OP_RESET_FLAGS: begin
          host_full = 1'b0;
          snd_full  = 1'b0;
        end
        OP_SND_DATA_RD: begin
          host_full   = 1'b0;
          r.read_data = h2s_word;
        end
        OP_SND_DATA_WR: begin
          s2h_word = (s2h_word & ~it.byte_mask) | (it.data & it.byte_mask);
          snd_full = 1'b1;
        end
        OP_SND_STATUS:   r.read_data = {host_full, snd_full, SndStatusLow};
        OP_LATCH_WR:     latch[it.offset[2:0]] = it.offset[3];
        OP_IRQ_CLR:      irq3_pending = 1'b0;
        OP_COM_RD:       r.read_data = ram_on ? ram[idx] : GatedReadVal;
        OP_COM_WR: begin
          if (ram_on) ram[idx] = (ram[idx] & ~it.byte_mask) | (it.data & it.byte_mask);
        end
        OP_DAC_WR: begin
          r.dac_value  = it.data[15:4] ^ DacMsbFlip;
          r.dac_strobe = 1'b1;
        end
        OP_GEN_IRQ:      irq3_pending = 1'b1;
        OP_ADDR_WR: begin
          if (it.offset == '0) snd_ptr[19:16] = it.data[3:0];
          else                 snd_ptr[15:0]  = it.data;
        end
        OP_ROM_RD: begin
          ptr_op      = 1'b1;
          r.read_data = ({1'b0, snd_ptr} < rom_len) ? {1'b0, it.rom_byte, 7'b0} : '0;
          snd_ptr     = snd_ptr + 1'b1;
        end
        OP_DSP_COM_RD: begin
          ptr_op      = 1'b1;
          r.read_data = ram[snd_ptr % SHARED_WORDS];
          snd_ptr     = snd_ptr + 1'b1;
        end
      endcase
      // Pointer opcodes report the address they used; the rest the one left.
      if (!ptr_op) r.rom_address = snd_ptr;
      r.host_irq_line = host_full;
      r.dsp_irq_line  = irq3_pending;
      r.latch_bits    = latch;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("read_data",     want.read_data,     got.read_data);
      compare_field("host_irq_line", want.host_irq_line, got.host_irq_line);
      compare_field("dsp_irq_line",  want.dsp_irq_line,  got.dsp_irq_line);
      compare_field("dac_value",     want.dac_value,     got.dac_value);
      compare_field("dac_strobe",    want.dac_strobe,    got.dac_strobe);
      compare_field("latch_bits",    want.latch_bits,    got.latch_bits);
      compare_field("rom_address",   want.rom_address,   got.rom_address);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b1; // pulled low at time zero
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [RomLenW-1:0] cfg_wdata_i = '0;

  bit                 gaps_on      = 1'b1; // random stalls on both sides
  bit                 hold_off_req = 1'b0; // one long output stall
  int unsigned        cycles       = 0;
  mailbox_scoreboard  board;

  cpu_mailbox_and_shared_ram_interface #(
    .SHARED_WORDS(SHARED_WORDS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run watchdog; the limit covers the RAM clearing pass and every stall.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cpu_mailbox_and_shared_ram_interface regression: fail");
      $finish;
    end
  end

  // Handshake monitor. Results are checked before the new access is noted,
  // so a stray result can never be matched against an access of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(out_item_o);
      if (in_valid_i && in_ready_o)   board.note_access(in_item_i);
    end
  end

  // Result side: random stalls, plus one long hold-off on request so the
  // pipeline fills and pushes back on the sender.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(0, 99) < 32);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t make_item(opcode_e op, logic [8:0] offset,
                                         logic [15:0] data, logic [15:0] mask,
                                         logic [7:0] rbyte);
    in_item_t it;
    it.opcode    = op;
    it.offset    = offset;
    it.data      = data;
    it.byte_mask = mask;
    it.rom_byte  = rbyte;
    return it;
  endfunction

  function automatic logic [15:0] random_mask();
    case ($urandom_range(0, 3))
      0:       return 16'hffff;
      1:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Single random access, biased toward latch writes that flip the RAM
  // enable and toward shared RAM traffic so both gated and open paths run.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it   = make_item(opcode_e'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                     16'($urandom), random_mask(), 8'($urandom));
    if (pick < 15) begin
      it.opcode = OP_LATCH_WR;
      if ($urandom_range(0, 1)) begin
        it.offset[2:0] = 3'(LatchRamEnBit);
        it.offset[3]   = ($urandom_range(0, 2) != 0);
      end
    end else if (pick < 35) begin
      it.opcode = $urandom_range(0, 1) ? OP_COM_RD : OP_COM_WR;
    end
    return it;
  endfunction

  // Present one item and hold it until taken. Random idle cycles go first.
  task automatic send_item(input in_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Only called with nothing in flight.
  task automatic write_rom_length(input logic [RomLenW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_rom_length(v);
  endtask

  // Random traffic: pointer loads followed by read runs, full mailbox
  // exchanges, and single random accesses.
  task automatic run_traffic(input int n);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        len = $urandom_range(2, 8);
        send_item(make_item(OP_ADDR_WR, 9'd0, 16'($urandom), random_mask(), 8'($urandom)));
        send_item(make_item(OP_ADDR_WR, 9'($urandom_range(1, 511)), 16'($urandom),
                            random_mask(), 8'($urandom)));
        repeat (len) begin
          send_item(make_item($urandom_range(0, 1) ? OP_ROM_RD : OP_DSP_COM_RD,
                              9'($urandom_range(0, 511)), 16'($urandom), random_mask(),
                              8'($urandom)));
        end
        sent += len + 2;
      end else if (kind < 35) begin
        send_item(make_item(OP_HOST_DATA_WR, 9'($urandom), 16'($urandom), random_mask(),
                            8'($urandom)));
        send_item(make_item(OP_SND_STATUS, 9'($urandom), 16'($urandom), random_mask(),
                            8'($urandom)));
        send_item(make_item(OP_SND_DATA_RD, 9'($urandom), 16'($urandom), random_mask(),
                            8'($urandom)));
        send_item(make_item(OP_SND_DATA_WR, 9'($urandom), 16'($urandom), random_mask(),
                            8'($urandom)));
        send_item(make_item(OP_HOST_STATUS, 9'($urandom), 16'($urandom), random_mask(),
                            8'($urandom)));
        send_item(make_item(OP_HOST_DATA_RD, 9'($urandom), 16'($urandom), random_mask(),
                            8'($urandom)));
        sent += 6;
      end else begin
        send_item(random_item());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [RomLenW-1:0] rom_lengths[5];
    rst_ni <= 1'b0;
    board = new();
    rom_lengths[0] = RomLenReset;                        // whole ROM present
    rom_lengths[1] = '0;                                 // no ROM at all
    rom_lengths[2] = 21'($urandom_range(0, 1048576));
    rom_lengths[3] = 21'd1;
    rom_lengths[4] = 21'hfffff;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // RAM clearing pass: the block takes nothing until it is done.
    while (!in_ready_o) @(posedge clk_i);

    // Directed part: half the ROM present so the top pointer reads as absent.
    write_rom_length(21'h080000);
    send_item(make_item(OP_HOST_STATUS,  9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_SND_STATUS,   9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_HOST_DATA_WR, 9'd0,   16'hffff, 16'h0000, 8'h00));
    send_item(make_item(OP_HOST_STATUS,  9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_SND_DATA_RD,  9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_HOST_DATA_WR, 9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_SND_DATA_WR,  9'd0,   16'hffff, 16'h00ff, 8'h00));
    send_item(make_item(OP_SND_STATUS,   9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_RESET_FLAGS,  9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_HOST_DATA_RD, 9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_GEN_IRQ,      9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_IRQ_CLR,      9'd0,   16'h0000, 16'h0000, 8'h00));
    // Open the shared RAM (latch bit 3 set), upper offset bits set too.
    send_item(make_item(OP_LATCH_WR,     9'h1fb, 16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_COM_WR,       9'd511, 16'hffff, 16'hffff, 8'h00));
    send_item(make_item(OP_COM_WR,       9'd0,   16'ha5a5, 16'hf0f0, 8'h00));
    send_item(make_item(OP_COM_RD,       9'd511, 16'h0000, 16'h0000, 8'h00));
    // Pointer to the very top, then a ROM read past the length that wraps.
    send_item(make_item(OP_ADDR_WR,      9'd0,   16'hffff, 16'h0000, 8'h00));
    send_item(make_item(OP_ADDR_WR,      9'd1,   16'hffff, 16'h0000, 8'h00));
    send_item(make_item(OP_ROM_RD,       9'd0,   16'h0000, 16'h0000, 8'hff));
    // Close the RAM: the DSP still reads it, the sound CPU is gated.
    send_item(make_item(OP_LATCH_WR,     9'h003, 16'hffff, 16'hffff, 8'h00));
    send_item(make_item(OP_DSP_COM_RD,   9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_ROM_RD,       9'd0,   16'h0000, 16'h0000, 8'hff));
    send_item(make_item(OP_COM_RD,       9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_COM_WR,       9'd0,   16'h1234, 16'hffff, 8'h00));
    send_item(make_item(OP_DAC_WR,       9'd0,   16'h0000, 16'h0000, 8'h00));
    send_item(make_item(OP_DAC_WR,       9'd0,   16'hffff, 16'h0000, 8'h00));
    wait_drained();

    // Random phases, one per ROM length. The first runs with no stalls at
    // all; the third opens with the long output hold-off.
    foreach (rom_lengths[p]) begin
      write_rom_length(rom_lengths[p]);
      gaps_on = (p != 0);
      if (p == 2) hold_off_req = 1'b1;
      run_traffic(260);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d results never arrived", board.pending());
    end
    if (board.errors == 0 && board.pending() == 0) begin
      $display("cpu_mailbox_and_shared_ram_interface regression: pass");
    end else begin
      $display("cpu_mailbox_and_shared_ram_interface regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/cmsr_pkg.sv
rtl/cpu_mailbox_and_shared_ram_interface.sv
rtl/cmsr_checker.sv
tb/cpu_mailbox_and_shared_ram_interface_test.sv
